>>> rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int RANK_W   = 8;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   localparam logic FUNC_ENQUEUE = 1'b0;
   localparam logic FUNC_DEQUEUE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic                      func;
      logic signed [VALUE_W-1:0] item_value;
      logic [RANK_W-1:0]         item_rank;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] removed_value;
      logic [STATUS_W-1:0]       status;
      logic [OCC_W-1:0]          occupancy;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_INSERT,
      OP_REMOVE,
      OP_DROP_FULL,
      OP_DROP_EMPTY
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } dp_status_type;

   typedef enum logic {
      CTL_OPEN,
      CTL_HOLD
   } ctl_state_type;

endpackage

`default_nettype wire

>>> rtl/spq_ctrl.sv
`default_nettype none

module spq_ctrl
   import spq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic          req_func,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type dp_status,
   output dp_cmd_type         dp_cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;
   logic          accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_OPEN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      req_ready = (state_ff == CTL_OPEN) || rsp_ready;
      rsp_valid = (state_ff == CTL_HOLD);
      accept    = req_valid && req_ready;
      state_in  = state_ff;
      dp_cmd.op = OP_NONE;
      if (accept) begin
         state_in = CTL_HOLD;
         if (req_func == FUNC_ENQUEUE) begin
            dp_cmd.op = dp_status.full ? OP_DROP_FULL : OP_INSERT;
         end else begin
            dp_cmd.op = dp_status.empty ? OP_DROP_EMPTY : OP_REMOVE;
         end
      end else if (rsp_ready) begin
         state_in = CTL_OPEN;
      end
   end

`ifndef SYNTH
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request did not produce a response");

   a_no_insert_when_full: assert property (@(posedge clock) disable iff (reset)
      dp_status.full |-> (dp_cmd.op != OP_INSERT))
      else $error("insert issued while store full");
`endif

endmodule

`default_nettype wire

>>> rtl/spq_dp.sv
`default_nettype none

module spq_dp
   import spq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire req_type    req_data,
   input  wire dp_cmd_type dp_cmd,
   output dp_status_type   dp_status,
   output rsp_type         rsp_data
);

   logic signed [VALUE_W-1:0] val_ff  [CAPACITY];
   logic signed [VALUE_W-1:0] val_in  [CAPACITY];
   logic [RANK_W-1:0]         rank_ff [CAPACITY];
   logic [RANK_W-1:0]         rank_in [CAPACITY];
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;
   logic [CAPACITY-1:0]       move;
   logic [CAPACITY-1:0]       at_end;

   assign dp_status.empty = (count_ff == '0);
   assign dp_status.full  = (count_ff == CNT_W'(CAPACITY));
   assign rsp_data        = rsp_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
      logic                      mv_prev;
      logic signed [VALUE_W-1:0] v_prev;
      logic [RANK_W-1:0]         r_prev;
      logic signed [VALUE_W-1:0] v_next;
      logic [RANK_W-1:0]         r_next;

      // entry moves down one slot when its rank is above the new one
      assign move[i]   = (CNT_W'(i) < count_ff) && (rank_ff[i] > req_data.item_rank);
      assign at_end[i] = (CNT_W'(i) == count_ff);

      if (i == 0) begin : g_first
         assign mv_prev = 1'b0;
         assign v_prev  = val_ff[i];
         assign r_prev  = rank_ff[i];
      end else begin : g_prev
         assign mv_prev = move[i-1];
         assign v_prev  = val_ff[i-1];
         assign r_prev  = rank_ff[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign v_next = val_ff[i];
         assign r_next = rank_ff[i];
      end else begin : g_next
         assign v_next = val_ff[i+1];
         assign r_next = rank_ff[i+1];
      end

      always_comb begin
         val_in[i]  = val_ff[i];
         rank_in[i] = rank_ff[i];
         unique case (dp_cmd.op)
            OP_INSERT: begin
               if (mv_prev) begin
                  val_in[i]  = v_prev;
                  rank_in[i] = r_prev;
               end else if (move[i] || at_end[i]) begin
                  val_in[i]  = req_data.item_value;
                  rank_in[i] = req_data.item_rank;
               end
            end
            OP_REMOVE: begin
               val_in[i]  = v_next;
               rank_in[i] = r_next;
            end
            default: begin
            end
         endcase
      end

      always_ff @(posedge clock) begin
         val_ff[i]  <= val_in[i];
         rank_ff[i] <= rank_in[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      rsp_in   = rsp_ff;
      unique case (dp_cmd.op)
         OP_INSERT: begin
            count_in             = count_ff + CNT_W'(1);
            rsp_in.removed_value = '0;
            rsp_in.status        = ST_INSERTED;
         end
         OP_REMOVE: begin
            count_in             = count_ff - CNT_W'(1);
            rsp_in.removed_value = val_ff[0];
            rsp_in.status        = ST_REMOVED;
         end
         OP_DROP_FULL: begin
            rsp_in.removed_value = '0;
            rsp_in.status        = ST_FULL;
         end
         OP_DROP_EMPTY: begin
            rsp_in.removed_value = '0;
            rsp_in.status        = ST_EMPTY;
         end
         default: begin
         end
      endcase
      rsp_in.occupancy = OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == OP_INSERT) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not advance count");

   a_remove_head: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == OP_REMOVE) |=> (rsp_ff.removed_value == $past(val_ff[0])))
      else $error("removed value is not the old head");
`endif

endmodule

`default_nettype wire

>>> rtl/sorted_priority_queue.sv
// sorted priority queue, lower rank served first, equal ranks in arrival order
// request channel (req_valid/req_ready/req_data): func selects enqueue or
// dequeue; item_value and item_rank matter for enqueue only
// response channel (rsp_valid/rsp_ready/rsp_data): one response per request
// with removed_value, status (inserted, removed, empty, full) and occupancy
// entries sit in a sorted register array; every slot compares its rank with
// the new one in parallel and shifts down or takes the new entry
// latency: response valid in the cycle after the request transfer
// throughput: one request per cycle while rsp_ready stays high
// a single output register holds the response; while the receiver stalls,
// req_ready is low and the store does not change
// reset clears the entry count and the response valid; entry contents are
// not cleared and never read before being written
`default_nettype none

module sorted_priority_queue
   import spq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_data.func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   spq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
